// ===== rtl/core/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg
// Types and constants shared by the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int TOL_BITS   = 16;
   localparam int POINT_BITS = 48;

   typedef enum logic [1:0] {
      REL_NONE     = 2'd0,
      REL_LINES    = 2'd1,
      REL_SEGMENTS = 2'd2
   } rel_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_start_x;
      logic signed [COORD_BITS-1:0] first_start_y;
      logic signed [COORD_BITS-1:0] first_end_x;
      logic signed [COORD_BITS-1:0] first_end_y;
      logic signed [COORD_BITS-1:0] second_start_x;
      logic signed [COORD_BITS-1:0] second_start_y;
      logic signed [COORD_BITS-1:0] second_end_x;
      logic signed [COORD_BITS-1:0] second_end_y;
   } req_type;

   typedef struct packed {
      logic [1:0]                   relation;
      logic                         point_valid;
      logic signed [POINT_BITS-1:0] point_x;
      logic signed [POINT_BITS-1:0] point_y;
   } rsp_type;

   // Classification that travels alongside the divider.
   typedef struct packed {
      rel_type relation;
      logic    point_valid;
      logic    neg_x;
      logic    neg_y;
   } side_type;

endpackage

// ===== rtl/core/sic_div.sv =====
// ----------------------------------------------------------------------------
// sic_div
// Restoring divider pipeline: one quotient bit per stage, x and y in step.
// ----------------------------------------------------------------------------
module sic_div #(
   parameter int NW = 70,
   parameter int TW = 36
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  sic_pkg::side_type in_side,
   input  logic [NW-1:0]     in_num_x,
   input  logic [NW-1:0]     in_num_y,
   input  logic [TW-1:0]     in_den,
   output logic              out_valid,
   output sic_pkg::side_type out_side,
   output logic [NW-1:0]     out_quo_x,
   output logic [NW-1:0]     out_quo_y
);

   logic [NW-1:0]     vld_ff;
   sic_pkg::side_type side_ff  [NW];
   logic [TW-1:0]     den_ff   [NW];
   logic [TW-1:0]     rem_x_ff [NW];
   logic [TW-1:0]     rem_y_ff [NW];
   logic [NW-1:0]     dq_x_ff  [NW];
   logic [NW-1:0]     dq_y_ff  [NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NW-2:0], in_valid};
      end
   end

   // Each stage shifts the next dividend bit into the remainder and puts the
   // quotient bit into the vacated low end of the dividend register.
   for (genvar k = 0; k < NW; k++) begin : g_stage
      sic_pkg::side_type side_src;
      logic [TW-1:0]     den_src;
      logic [TW-1:0]     rem_x_src;
      logic [TW-1:0]     rem_y_src;
      logic [NW-1:0]     dq_x_src;
      logic [NW-1:0]     dq_y_src;
      logic [TW:0]       trial_x;
      logic [TW:0]       trial_y;
      logic              ge_x;
      logic              ge_y;

      if (k == 0) begin : g_first
         assign side_src  = in_side;
         assign den_src   = in_den;
         assign rem_x_src = '0;
         assign rem_y_src = '0;
         assign dq_x_src  = in_num_x;
         assign dq_y_src  = in_num_y;
      end else begin : g_next
         assign side_src  = side_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign rem_x_src = rem_x_ff[k-1];
         assign rem_y_src = rem_y_ff[k-1];
         assign dq_x_src  = dq_x_ff[k-1];
         assign dq_y_src  = dq_y_ff[k-1];
      end

      assign trial_x = {rem_x_src, dq_x_src[NW-1]};
      assign trial_y = {rem_y_src, dq_y_src[NW-1]};
      assign ge_x    = trial_x >= {1'b0, den_src};
      assign ge_y    = trial_y >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k]  <= side_src;
            den_ff[k]   <= den_src;
            rem_x_ff[k] <= ge_x ? TW'(trial_x - {1'b0, den_src}) : TW'(trial_x);
            rem_y_ff[k] <= ge_y ? TW'(trial_y - {1'b0, den_src}) : TW'(trial_y);
            dq_x_ff[k]  <= {dq_x_src[NW-2:0], ge_x};
            dq_y_ff[k]  <= {dq_y_src[NW-2:0], ge_y};
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_side  = side_ff[NW-1];
   assign out_quo_x = dq_x_ff[NW-1];
   assign out_quo_y = dq_y_ff[NW-1];

endmodule

// ===== rtl/core/segment_intersection_classify.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classify
// Classifies two integer line segments and gives their crossing or midpoint.
// ----------------------------------------------------------------------------
// Usage: a segment pair enters on req_valid/req_ready as one transaction and
// one result leaves on rsp_valid/rsp_ready. The user must write the tolerance
// register through csr_write_enable/csr_write_data only while the block is
// idle; the block itself does not enforce this. Throughput is one
// transaction per cycle while the output queue has room. The pipeline holds
// eight arithmetic stages, then the bit-per-stage divider with NW stages, where
// NW = 3*COORD_BITS + 6 + FRAC_BITS, and then the output register.
// The whole pipeline advances together while the two-entry output queue has
// room; req_ready is high whenever fewer than two results wait, so a new pair
// is still taken while a finished result waits for the receiver. When the
// receiver stalls the queue fills and req_ready falls; nothing is lost.
// A synchronous reset empties the pipeline and the queue and clears the
// tolerance register to zero (exact parallel test).
// ----------------------------------------------------------------------------
module segment_intersection_classify #(
   parameter int FRAC_BITS = sic_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sic_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sic_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [sic_pkg::TOL_BITS-1:0]  csr_write_data
);

   localparam int CW = sic_pkg::COORD_BITS;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int TW = SW + 1;
   localparam int XW = DW + TW;
   localparam int MW = XW + 1;
   localparam int NW = MW + FRAC_BITS;
   localparam int LB = sic_pkg::TOL_BITS;
   localparam int QW = LB + SW;
   localparam int OW = sic_pkg::POINT_BITS;

   logic          adv;
   logic [7:0]    v_ff;
   logic [LB-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[6:0], req_valid};
      end
   end

   // Stage 1: edge vectors.
   logic signed [CW-1:0] s1_px_ff, s1_py_ff;
   logic signed [DW-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [DW-1:0] s1_cx_ff, s1_cy_ff, s1_dx_ff, s1_dy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff <= req_payload.first_start_x;
         s1_py_ff <= req_payload.first_start_y;
         s1_ax_ff <= DW'(req_payload.first_end_x) - DW'(req_payload.first_start_x);
         s1_ay_ff <= DW'(req_payload.first_end_y) - DW'(req_payload.first_start_y);
         s1_bx_ff <= DW'(req_payload.second_start_x) - DW'(req_payload.second_end_x);
         s1_by_ff <= DW'(req_payload.second_start_y) - DW'(req_payload.second_end_y);
         s1_cx_ff <= DW'(req_payload.first_start_x) - DW'(req_payload.second_start_x);
         s1_cy_ff <= DW'(req_payload.first_start_y) - DW'(req_payload.second_start_y);
         s1_dx_ff <= DW'(req_payload.second_end_x) - DW'(req_payload.first_start_x);
         s1_dy_ff <= DW'(req_payload.second_end_y) - DW'(req_payload.first_start_y);
      end
   end

   // Stage 2: products.
   logic signed [CW-1:0] s2_px_ff, s2_py_ff;
   logic signed [DW-1:0] s2_ax_ff, s2_ay_ff;
   logic signed [PW-1:0] s2_aybx_ff, s2_axby_ff, s2_axax_ff, s2_ayay_ff;
   logic signed [PW-1:0] s2_aycx_ff, s2_axcy_ff, s2_aycy_ff, s2_axcx_ff;
   logic signed [PW-1:0] s2_axdx_ff, s2_aydy_ff, s2_bycx_ff, s2_bxcy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_px_ff   <= s1_px_ff;
         s2_py_ff   <= s1_py_ff;
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_aybx_ff <= PW'(s1_ay_ff) * PW'(s1_bx_ff);
         s2_axby_ff <= PW'(s1_ax_ff) * PW'(s1_by_ff);
         s2_axax_ff <= PW'(s1_ax_ff) * PW'(s1_ax_ff);
         s2_ayay_ff <= PW'(s1_ay_ff) * PW'(s1_ay_ff);
         s2_aycx_ff <= PW'(s1_ay_ff) * PW'(s1_cx_ff);
         s2_axcy_ff <= PW'(s1_ax_ff) * PW'(s1_cy_ff);
         s2_aycy_ff <= PW'(s1_ay_ff) * PW'(s1_cy_ff);
         s2_axcx_ff <= PW'(s1_ax_ff) * PW'(s1_cx_ff);
         s2_axdx_ff <= PW'(s1_ax_ff) * PW'(s1_dx_ff);
         s2_aydy_ff <= PW'(s1_ay_ff) * PW'(s1_dy_ff);
         s2_bycx_ff <= PW'(s1_by_ff) * PW'(s1_cx_ff);
         s2_bxcy_ff <= PW'(s1_bx_ff) * PW'(s1_cy_ff);
      end
   end

   // Stage 3: denominator, squared length and numerators.
   logic signed [CW-1:0] s3_px_ff, s3_py_ff;
   logic signed [DW-1:0] s3_ax_ff, s3_ay_ff;
   logic signed [SW-1:0] s3_den_ff, s3_len_ff, s3_r_ff, s3_n1_ff, s3_n2_ff, s3_na_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_px_ff  <= s2_px_ff;
         s3_py_ff  <= s2_py_ff;
         s3_ax_ff  <= s2_ax_ff;
         s3_ay_ff  <= s2_ay_ff;
         s3_den_ff <= SW'(s2_aybx_ff) - SW'(s2_axby_ff);
         s3_len_ff <= SW'(s2_axax_ff) + SW'(s2_ayay_ff);
         s3_r_ff   <= SW'(s2_aycx_ff) - SW'(s2_axcy_ff);
         s3_n1_ff  <= -SW'(s2_aycy_ff) - SW'(s2_axcx_ff);
         s3_n2_ff  <= SW'(s2_axdx_ff) + SW'(s2_aydy_ff);
         s3_na_ff  <= SW'(s2_bycx_ff) - SW'(s2_bxcy_ff);
      end
   end

   // Stage 4: tolerance bound and magnitudes.
   logic signed [CW-1:0] s4_px_ff, s4_py_ff;
   logic signed [DW-1:0] s4_ax_ff, s4_ay_ff;
   logic signed [SW-1:0] s4_den_ff, s4_len_ff, s4_r_ff, s4_n1_ff, s4_n2_ff, s4_na_ff;
   logic [QW-1:0]        s4_bound_ff;
   logic [SW-1:0]        s4_absden_ff, s4_absr_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_px_ff     <= s3_px_ff;
         s4_py_ff     <= s3_py_ff;
         s4_ax_ff     <= s3_ax_ff;
         s4_ay_ff     <= s3_ay_ff;
         s4_den_ff    <= s3_den_ff;
         s4_len_ff    <= s3_len_ff;
         s4_r_ff      <= s3_r_ff;
         s4_n1_ff     <= s3_n1_ff;
         s4_n2_ff     <= s3_n2_ff;
         s4_na_ff     <= s3_na_ff;
         s4_bound_ff  <= QW'(tol_ff) * QW'($unsigned(s3_len_ff));
         s4_absden_ff <= (s3_den_ff < 0) ? $unsigned(-s3_den_ff) : $unsigned(s3_den_ff);
         s4_absr_ff   <= (s3_r_ff < 0) ? $unsigned(-s3_r_ff) : $unsigned(s3_r_ff);
      end
   end

   // Stage 5: parallel and collinear decisions.
   logic signed [CW-1:0] s5_px_ff, s5_py_ff;
   logic signed [DW-1:0] s5_ax_ff, s5_ay_ff;
   logic signed [SW-1:0] s5_den_ff, s5_len_ff, s5_r_ff, s5_n1_ff, s5_n2_ff, s5_na_ff;
   logic                 s5_par_ff, s5_col_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_px_ff  <= s4_px_ff;
         s5_py_ff  <= s4_py_ff;
         s5_ax_ff  <= s4_ax_ff;
         s5_ay_ff  <= s4_ay_ff;
         s5_den_ff <= s4_den_ff;
         s5_len_ff <= s4_len_ff;
         s5_r_ff   <= s4_r_ff;
         s5_n1_ff  <= s4_n1_ff;
         s5_n2_ff  <= s4_n2_ff;
         s5_na_ff  <= s4_na_ff;
         s5_par_ff <= {s4_absden_ff, {LB{1'b0}}} <= s4_bound_ff;
         s5_col_ff <= {s4_absr_ff, {LB{1'b0}}} <= s4_bound_ff;
      end
   end

   // Stage 6: parameter numerator and denominator, relation.
   logic signed [SW-1:0] n_max, n_min, nb;
   logic signed [TW-1:0] s6_tn_in, s6_td_in;
   sic_pkg::rel_type     s6_rel_in;
   logic                 s6_pv_in;

   always_comb begin
      n_max     = (s5_n1_ff > s5_n2_ff) ? s5_n1_ff : s5_n2_ff;
      n_min     = (s5_n1_ff < s5_n2_ff) ? s5_n1_ff : s5_n2_ff;
      nb        = -s5_r_ff;
      s6_tn_in  = TW'(s5_na_ff);
      s6_td_in  = TW'(s5_den_ff);
      s6_pv_in  = 1'b1;
      s6_rel_in = sic_pkg::REL_SEGMENTS;
      if (s5_par_ff) begin
         s6_td_in = TW'(s5_len_ff) + TW'(s5_len_ff);
         s6_pv_in = s5_len_ff != '0;
         if (!s5_col_ff) begin
            s6_pv_in  = 1'b0;
            s6_rel_in = sic_pkg::REL_NONE;
         end else if (s5_n1_ff < 0 || s5_n2_ff < 0) begin
            // Second segment reaches behind the start of the first.
            if (n_max > s5_len_ff) begin
               s6_tn_in = TW'(s5_len_ff);
            end else begin
               s6_tn_in = TW'(n_max);
               if (n_max < 0) begin
                  s6_rel_in = sic_pkg::REL_LINES;
               end
            end
         end else if (n_min > s5_len_ff) begin
            s6_tn_in  = TW'(s5_len_ff) + TW'(n_min);
            s6_rel_in = sic_pkg::REL_LINES;
         end else if (s5_n2_ff > s5_len_ff) begin
            s6_tn_in = TW'(s5_len_ff) + TW'(n_min);
         end else begin
            s6_tn_in = TW'(s5_n1_ff) + TW'(s5_n2_ff);
         end
      end else if (s5_den_ff > 0) begin
         if (s5_na_ff < 0 || s5_na_ff > s5_den_ff || nb < 0 || nb > s5_den_ff) begin
            s6_rel_in = sic_pkg::REL_LINES;
         end
      end else begin
         if (s5_na_ff > 0 || s5_na_ff < s5_den_ff || nb > 0 || nb < s5_den_ff) begin
            s6_rel_in = sic_pkg::REL_LINES;
         end
      end
   end

   logic signed [CW-1:0] s6_px_ff, s6_py_ff;
   logic signed [DW-1:0] s6_ax_ff, s6_ay_ff;
   logic signed [TW-1:0] s6_tn_ff, s6_td_ff;
   sic_pkg::rel_type     s6_rel_ff;
   logic                 s6_pv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_px_ff  <= s5_px_ff;
         s6_py_ff  <= s5_py_ff;
         s6_ax_ff  <= s5_ax_ff;
         s6_ay_ff  <= s5_ay_ff;
         s6_tn_ff  <= s6_tn_in;
         s6_td_ff  <= s6_td_in;
         s6_rel_ff <= s6_rel_in;
         s6_pv_ff  <= s6_pv_in;
      end
   end

   // Stage 7: scaled base and direction terms.
   logic signed [XW-1:0] s7_bx_ff, s7_by_ff, s7_dx_ff, s7_dy_ff;
   logic [TW-1:0]        s7_tdabs_ff;
   logic                 s7_tdneg_ff;
   sic_pkg::rel_type     s7_rel_ff;
   logic                 s7_pv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_bx_ff    <= XW'(s6_px_ff) * XW'(s6_td_ff);
         s7_by_ff    <= XW'(s6_py_ff) * XW'(s6_td_ff);
         s7_dx_ff    <= XW'(s6_ax_ff) * XW'(s6_tn_ff);
         s7_dy_ff    <= XW'(s6_ay_ff) * XW'(s6_tn_ff);
         s7_tdabs_ff <= (s6_td_ff < 0) ? $unsigned(-s6_td_ff) : $unsigned(s6_td_ff);
         s7_tdneg_ff <= s6_td_ff < 0;
         s7_rel_ff   <= s6_rel_ff;
         s7_pv_ff    <= s6_pv_ff;
      end
   end

   // Stage 8: fixed-point dividend, split into sign and magnitude.
   logic signed [NW-1:0] num_x, num_y;
   logic [NW-1:0]        s8_mag_x_ff, s8_mag_y_ff;
   logic [TW-1:0]        s8_den_ff;
   sic_pkg::side_type    s8_side_ff;

   assign num_x = NW'(MW'(s7_bx_ff) + MW'(s7_dx_ff)) <<< FRAC_BITS;
   assign num_y = NW'(MW'(s7_by_ff) + MW'(s7_dy_ff)) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_mag_x_ff             <= (num_x < 0) ? $unsigned(-num_x) : $unsigned(num_x);
         s8_mag_y_ff             <= (num_y < 0) ? $unsigned(-num_y) : $unsigned(num_y);
         s8_den_ff               <= s7_tdabs_ff;
         s8_side_ff.relation     <= s7_rel_ff;
         s8_side_ff.point_valid  <= s7_pv_ff;
         s8_side_ff.neg_x        <= (num_x < 0) != s7_tdneg_ff;
         s8_side_ff.neg_y        <= (num_y < 0) != s7_tdneg_ff;
      end
   end

   logic              div_valid;
   sic_pkg::side_type div_side;
   logic [NW-1:0]     div_quo_x, div_quo_y;

   sic_div #(
      .NW (NW),
      .TW (TW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v_ff[7]),
      .in_side   (s8_side_ff),
      .in_num_x  (s8_mag_x_ff),
      .in_num_y  (s8_mag_y_ff),
      .in_den    (s8_den_ff),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quo_x (div_quo_x),
      .out_quo_y (div_quo_y)
   );

   function automatic logic [OW-1:0] saturate(input logic [NW-1:0] q, input logic neg);
      logic at_least;
      logic above;
      at_least = |q[NW-1:OW-1];
      above    = (|q[NW-1:OW]) || (q[OW-1] && (|q[OW-2:0]));
      if (neg) begin
         saturate = above ? {1'b1, {(OW-1){1'b0}}} : -q[OW-1:0];
      end else begin
         saturate = at_least ? {1'b0, {(OW-1){1'b1}}} : q[OW-1:0];
      end
   endfunction

   sic_pkg::rsp_type result;

   always_comb begin
      result.relation    = div_side.relation;
      result.point_valid = div_side.point_valid;
      result.point_x     = '0;
      result.point_y     = '0;
      if (div_side.point_valid) begin
         result.point_x = saturate(div_quo_x, div_side.neg_x);
         result.point_y = saturate(div_quo_y, div_side.neg_y);
      end
   end

   // Two-entry output queue; the pipeline moves only while it has room.
   logic [1:0]       count_ff, count_in;
   sic_pkg::rsp_type head_ff, spare_ff;
   logic             push, pop;

   assign adv       = count_ff < 2'd2;
   assign req_ready = adv;
   assign push      = adv && div_valid;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_payload = head_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
         if (push) begin
            head_ff <= result;
         end
      end else if (count_ff == 2'd1) begin
         if (push) begin
            spare_ff <= result;
         end
      end else if (pop) begin
         head_ff <= spare_ff;
      end
   end

endmodule
